>>> sv/nmea_rmc_field_extractor_assert.svh
// Assertion macros shared by the checker of the RMC field extractor.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH

// Check a property on every rising clock edge, masked while reset is held
`define NRMC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nmea_rmc check failed");

// Check a property on every rising clock edge, reset included
`define NRMC_ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("nmea_rmc check failed");

`endif

>>> sv/nmea_rmc_pkg.sv
// Shared constants, types and the fraction scaling function of the RMC extractor.
// No dependencies; used by the parser, the finish stage and the top level.
package nmea_rmc_pkg;

  // Sentence limits
  localparam int MAX_BODY    = 60;
  localparam int FRAC_DIGITS = 4;
  localparam int SPEED_FRAC  = 2;
  localparam int MAX_FRAC    = (FRAC_DIGITS > SPEED_FRAC) ? FRAC_DIGITS : SPEED_FRAC;
  localparam int BODY_W      = $clog2(MAX_BODY + 1);
  localparam int FRAC_W      = $clog2(MAX_FRAC + 1);
  localparam int POW_W       = $clog2(10 ** MAX_FRAC + 1);

  // Field widths
  localparam int LAT_W     = 27;
  localparam int LON_W     = 30;
  localparam int SPD_W     = 29;
  localparam int SPD_ACC_W = 20;
  localparam int HEAD_W    = 10;
  localparam int ACC_W     = 30;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 4;
  localparam int KNOT_W    = 10;

  // Word layout on the result channel
  localparam int OUT_BITS    = 1 + LAT_W + LON_W + SPD_W + HEAD_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Saturation limits and scale factors
  localparam logic [ACC_W-1:0]  LAT_MAX     = ACC_W'(99999999);
  localparam logic [ACC_W-1:0]  LON_MAX     = ACC_W'(999999999);
  localparam logic [ACC_W-1:0]  SPD_ACC_MAX = ACC_W'(999999);
  localparam logic [HEAD_W-1:0] HEAD_MAX    = HEAD_W'(999);
  localparam logic [KNOT_W-1:0] KNOT_FACTOR = KNOT_W'(514);
  localparam logic [FRAC_W-1:0] FRAC_POS    = FRAC_W'(FRAC_DIGITS);
  localparam logic [FRAC_W-1:0] FRAC_SPD    = FRAC_W'(SPEED_FRAC);

  // Body field numbers
  localparam logic [IDX_W-1:0] FLD_STATUS = IDX_W'(1);
  localparam logic [IDX_W-1:0] FLD_LAT    = IDX_W'(2);
  localparam logic [IDX_W-1:0] FLD_LON    = IDX_W'(4);
  localparam logic [IDX_W-1:0] FLD_SPEED  = IDX_W'(6);
  localparam logic [IDX_W-1:0] FLD_HEAD   = IDX_W'(7);
  localparam logic [IDX_W-1:0] FLD_LAST   = IDX_W'(15);

  // Characters kept per numeric field
  localparam logic [CNT_W-1:0] LAT_CHARS = CNT_W'(9);
  localparam logic [CNT_W-1:0] LON_CHARS = CNT_W'(10);
  localparam logic [CNT_W-1:0] SPD_CHARS = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(15);

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;

  // Sentence snapshot taken when a sentence closes, before final scaling
  typedef struct packed {
    logic                 status;
    logic [LAT_W-1:0]     lat;
    logic [LON_W-1:0]     lon;
    logic [SPD_ACC_W-1:0] speed;
    logic [HEAD_W-1:0]    heading;
    logic [IDX_W-1:0]     field;
    logic [FRAC_W-1:0]    frac;
  } sentence_t;

  // Power of ten for a small exponent
  function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] k);
    logic [POW_W-1:0] p;
    p = POW_W'(1);
    for (int i = 0; i < MAX_FRAC; i++) begin
      if (FRAC_W'(i) < k) begin
        p = p * POW_W'(10);
      end
    end
    return p;
  endfunction

  // Pad missing fraction digits with zeros, saturating at vmax
  function automatic logic [ACC_W-1:0] scale_sat(input logic [ACC_W-1:0]  acc,
                                                input logic [FRAC_W-1:0] done,
                                                input logic [FRAC_W-1:0] fmax,
                                                input logic [ACC_W-1:0]  vmax);
    logic [FRAC_W-1:0]      k;
    logic [ACC_W+POW_W-1:0] prod;
    k    = (done < fmax) ? (fmax - done) : '0;
    prod = {{POW_W{1'b0}}, acc} * {{ACC_W{1'b0}}, pow10(k)};
    return (prod > {{POW_W{1'b0}}, vmax}) ? vmax : prod[ACC_W-1:0];
  endfunction

endpackage

>>> sv/nmea_rmc_parse.sv
// Character parser: input word register, header match and per-field accumulators.
// Depends on nmea_rmc_pkg; hands a sentence snapshot to nmea_rmc_finish.
module nmea_rmc_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,
  output logic                   snap_valid,
  input  logic                   snap_ready,
  output nmea_rmc_pkg::sentence_t snap_data
);

  localparam logic [2:0] HDR_IDLE = 3'd0;
  localparam logic [2:0] HDR_ONE  = 3'd1;
  localparam logic [2:0] HDR_LAST = 3'd6;
  localparam logic [2:0] IN_BODY  = 3'd7;

  // Header character expected at each match position
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = nmea_rmc_pkg::CH_DOLLAR;
      3'd1:    ch = nmea_rmc_pkg::CH_G;
      3'd2:    ch = nmea_rmc_pkg::CH_P;
      3'd3:    ch = nmea_rmc_pkg::CH_R;
      3'd4:    ch = nmea_rmc_pkg::CH_M;
      3'd5:    ch = nmea_rmc_pkg::CH_C;
      default: ch = nmea_rmc_pkg::CH_COMMA;
    endcase
    return ch;
  endfunction

  // Input word register
  logic       byte_valid_r;
  logic [7:0] byte_r;

  // Parser state
  logic [2:0]                           header_pos_r, header_pos_nxt;
  logic [nmea_rmc_pkg::IDX_W-1:0]       field_idx_r, field_idx_nxt;
  logic [nmea_rmc_pkg::CNT_W-1:0]       char_cnt_r, char_cnt_nxt;
  logic [nmea_rmc_pkg::BODY_W-1:0]      body_len_r, body_len_nxt;
  logic [nmea_rmc_pkg::FRAC_W-1:0]      frac_r, frac_nxt;
  logic                                 point_r, point_nxt;
  logic                                 stop_r, stop_nxt;
  logic                                 status_r, status_nxt;
  logic [nmea_rmc_pkg::LAT_W-1:0]       lat_r, lat_nxt;
  logic [nmea_rmc_pkg::LON_W-1:0]       lon_r, lon_nxt;
  logic [nmea_rmc_pkg::SPD_ACC_W-1:0]   speed_r, speed_nxt;
  logic [nmea_rmc_pkg::HEAD_W-1:0]      head_r, head_nxt;
  logic                                 head_done_r, head_done_nxt;

  // Snapshot register
  logic                    snap_valid_r;
  nmea_rmc_pkg::sentence_t snap_r, snap_nxt;

  // Shared number unit
  logic                                is_num;
  logic [nmea_rmc_pkg::ACC_W-1:0]      num_acc, num_max, num_scaled;
  logic [nmea_rmc_pkg::FRAC_W-1:0]     num_fmax;
  logic [nmea_rmc_pkg::CNT_W-1:0]      num_lim;
  logic [nmea_rmc_pkg::ACC_W+3:0]      feed_sum;
  logic [nmea_rmc_pkg::ACC_W-1:0]      feed_acc;
  logic [nmea_rmc_pkg::HEAD_W+3:0]     head_sum;
  logic [nmea_rmc_pkg::HEAD_W-1:0]     head_feed;
  logic                                is_digit;
  logic [3:0]                          digit;

  logic emit_hit;
  logic snap_free;
  logic step_go;

  assign is_digit  = (byte_r >= nmea_rmc_pkg::CH_ZERO) && (byte_r <= nmea_rmc_pkg::CH_NINE);
  assign digit     = byte_r[3:0];
  assign snap_free = !snap_valid_r || snap_ready;
  assign step_go   = byte_valid_r && (!emit_hit || snap_free);
  assign in_tready = !byte_valid_r || step_go;

  // Select the accumulator of the current numeric field
  always_comb begin
    is_num   = 1'b1;
    num_acc  = '0;
    num_max  = '0;
    num_fmax = '0;
    num_lim  = '0;
    unique case (field_idx_r)
      nmea_rmc_pkg::FLD_LAT: begin
        num_acc  = nmea_rmc_pkg::ACC_W'(lat_r);
        num_max  = nmea_rmc_pkg::LAT_MAX;
        num_fmax = nmea_rmc_pkg::FRAC_POS;
        num_lim  = nmea_rmc_pkg::LAT_CHARS;
      end
      nmea_rmc_pkg::FLD_LON: begin
        num_acc  = nmea_rmc_pkg::ACC_W'(lon_r);
        num_max  = nmea_rmc_pkg::LON_MAX;
        num_fmax = nmea_rmc_pkg::FRAC_POS;
        num_lim  = nmea_rmc_pkg::LON_CHARS;
      end
      nmea_rmc_pkg::FLD_SPEED: begin
        num_acc  = nmea_rmc_pkg::ACC_W'(speed_r);
        num_max  = nmea_rmc_pkg::SPD_ACC_MAX;
        num_fmax = nmea_rmc_pkg::FRAC_SPD;
        num_lim  = nmea_rmc_pkg::SPD_CHARS;
      end
      default: is_num = 1'b0;
    endcase
  end

  // Multiply by ten and add the digit, saturating; scale on field close
  always_comb begin
    feed_sum   = {num_acc, 3'b000} + {2'b00, num_acc, 1'b0} +
                 {{nmea_rmc_pkg::ACC_W{1'b0}}, digit};
    feed_acc   = (feed_sum > {4'b0000, num_max}) ? num_max
                                                  : feed_sum[nmea_rmc_pkg::ACC_W-1:0];
    num_scaled = nmea_rmc_pkg::scale_sat(num_acc, frac_r, num_fmax, num_max);
    head_sum   = {head_r, 3'b000} + {2'b00, head_r, 1'b0} +
                 {{nmea_rmc_pkg::HEAD_W{1'b0}}, digit};
    head_feed  = (head_sum > {4'b0000, nmea_rmc_pkg::HEAD_MAX}) ? nmea_rmc_pkg::HEAD_MAX
                 : head_sum[nmea_rmc_pkg::HEAD_W-1:0];
  end

  // Next parser state for the word in the input register
  always_comb begin
    header_pos_nxt = header_pos_r;
    field_idx_nxt  = field_idx_r;
    char_cnt_nxt   = char_cnt_r;
    body_len_nxt   = body_len_r;
    frac_nxt       = frac_r;
    point_nxt      = point_r;
    stop_nxt       = stop_r;
    status_nxt     = status_r;
    lat_nxt        = lat_r;
    lon_nxt        = lon_r;
    speed_nxt      = speed_r;
    head_nxt       = head_r;
    head_done_nxt  = head_done_r;
    emit_hit       = 1'b0;
    snap_nxt       = '{status: status_r, lat: lat_r, lon: lon_r, speed: speed_r,
                       heading: head_r, field: field_idx_r, frac: frac_r};

    if (header_pos_r != IN_BODY) begin
      // Match the header, restart on a stray dollar
      if (byte_r == hdr_char(header_pos_r)) begin
        header_pos_nxt = header_pos_r + 3'd1;
        if (header_pos_r == HDR_LAST) begin
          field_idx_nxt = '0;
          body_len_nxt  = '0;
          status_nxt    = 1'b0;
          lat_nxt       = '0;
          lon_nxt       = '0;
          speed_nxt     = '0;
          head_nxt      = '0;
          char_cnt_nxt  = '0;
          frac_nxt      = '0;
          point_nxt     = 1'b0;
          stop_nxt      = 1'b0;
          head_done_nxt = 1'b0;
        end
      end else begin
        header_pos_nxt = (byte_r == nmea_rmc_pkg::CH_DOLLAR) ? HDR_ONE : HDR_IDLE;
      end
    end else if (byte_r == nmea_rmc_pkg::CH_STAR) begin
      // Close the sentence on the checksum marker
      emit_hit       = byte_valid_r;
      header_pos_nxt = HDR_IDLE;
    end else begin
      if (byte_r == nmea_rmc_pkg::CH_COMMA) begin
        // Close the field: pad its fraction, move to the next one
        if (is_num) begin
          unique case (field_idx_r)
            nmea_rmc_pkg::FLD_LAT:   lat_nxt   = num_scaled[nmea_rmc_pkg::LAT_W-1:0];
            nmea_rmc_pkg::FLD_LON:   lon_nxt   = num_scaled[nmea_rmc_pkg::LON_W-1:0];
            default:                 speed_nxt = num_scaled[nmea_rmc_pkg::SPD_ACC_W-1:0];
          endcase
        end
        if (field_idx_r != nmea_rmc_pkg::FLD_LAST) begin
          field_idx_nxt = field_idx_r + 1'b1;
        end
        char_cnt_nxt  = '0;
        frac_nxt      = '0;
        point_nxt     = 1'b0;
        stop_nxt      = 1'b0;
        head_done_nxt = 1'b0;
      end else begin
        if (char_cnt_r != nmea_rmc_pkg::CNT_LAST) begin
          char_cnt_nxt = char_cnt_r + 1'b1;
        end
        if (field_idx_r == nmea_rmc_pkg::FLD_STATUS) begin
          if (char_cnt_r == '0) begin
            status_nxt = (byte_r == nmea_rmc_pkg::CH_A);
          end
        end else if (field_idx_r == nmea_rmc_pkg::FLD_HEAD) begin
          // Heading keeps leading digits only
          if (!head_done_r) begin
            if (is_digit) begin
              head_nxt = head_feed;
            end else begin
              head_done_nxt = 1'b1;
            end
          end
        end else if (is_num && (char_cnt_r < num_lim) && !stop_r) begin
          // Digits with at most one point; anything else ends the number
          if (is_digit) begin
            if (!(point_r && (frac_r >= num_fmax))) begin
              if (point_r) begin
                frac_nxt = frac_r + 1'b1;
              end
              unique case (field_idx_r)
                nmea_rmc_pkg::FLD_LAT:   lat_nxt   = feed_acc[nmea_rmc_pkg::LAT_W-1:0];
                nmea_rmc_pkg::FLD_LON:   lon_nxt   = feed_acc[nmea_rmc_pkg::LON_W-1:0];
                default:                 speed_nxt = feed_acc[nmea_rmc_pkg::SPD_ACC_W-1:0];
              endcase
            end
          end else if ((byte_r == nmea_rmc_pkg::CH_POINT) && !point_r) begin
            point_nxt = 1'b1;
          end else begin
            stop_nxt = 1'b1;
          end
        end
      end
      // Count body characters; close at the length limit
      body_len_nxt = body_len_r + 1'b1;
      if (body_len_nxt >= nmea_rmc_pkg::BODY_W'(nmea_rmc_pkg::MAX_BODY)) begin
        emit_hit       = byte_valid_r;
        header_pos_nxt = HDR_IDLE;
        snap_nxt       = '{status: status_nxt, lat: lat_nxt, lon: lon_nxt,
                           speed: speed_nxt, heading: head_nxt, field: field_idx_nxt,
                           frac: frac_nxt};
      end
    end
  end

  // Load the input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (in_tready) begin
      byte_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
  end

  // Advance the parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_pos_r <= HDR_IDLE;
      field_idx_r  <= '0;
      char_cnt_r   <= '0;
      body_len_r   <= '0;
      frac_r       <= '0;
      point_r      <= 1'b0;
      stop_r       <= 1'b0;
      status_r     <= 1'b0;
      head_done_r  <= 1'b0;
    end else if (step_go) begin
      header_pos_r <= header_pos_nxt;
      field_idx_r  <= field_idx_nxt;
      char_cnt_r   <= char_cnt_nxt;
      body_len_r   <= body_len_nxt;
      frac_r       <= frac_nxt;
      point_r      <= point_nxt;
      stop_r       <= stop_nxt;
      status_r     <= status_nxt;
      head_done_r  <= head_done_nxt;
    end
    if (step_go) begin
      lat_r   <= lat_nxt;
      lon_r   <= lon_nxt;
      speed_r <= speed_nxt;
      head_r  <= head_nxt;
    end
  end

  // Hold the closed sentence until the finish stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (snap_free) begin
      snap_valid_r <= step_go && emit_hit;
    end
    if (snap_free && step_go && emit_hit) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap_data  = snap_r;

endmodule

>>> sv/nmea_rmc_finish.sv
// Finish stage: pads the open field's fraction, then converts knots and drives results.
// Depends on nmea_rmc_pkg; fed by nmea_rmc_parse.
module nmea_rmc_finish (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    snap_valid,
  output logic                                    snap_ready,
  input  nmea_rmc_pkg::sentence_t                  snap_data,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [nmea_rmc_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  // Scaled stage
  logic                                 sc_valid_r;
  logic                                 sc_status_r;
  logic [nmea_rmc_pkg::LAT_W-1:0]       sc_lat_r, sc_lat_nxt;
  logic [nmea_rmc_pkg::LON_W-1:0]       sc_lon_r, sc_lon_nxt;
  logic [nmea_rmc_pkg::SPD_ACC_W-1:0]   sc_speed_r, sc_speed_nxt;
  logic [nmea_rmc_pkg::HEAD_W-1:0]      sc_head_r;

  // Output stage
  logic                                 out_valid_r;
  logic                                 out_status_r;
  logic [nmea_rmc_pkg::LAT_W-1:0]       out_lat_r;
  logic [nmea_rmc_pkg::LON_W-1:0]       out_lon_r;
  logic [nmea_rmc_pkg::SPD_W-1:0]       out_speed_r;
  logic [nmea_rmc_pkg::HEAD_W-1:0]      out_head_r;

  logic [nmea_rmc_pkg::ACC_W-1:0]       fin_acc, fin_max, fin_scaled;
  logic [nmea_rmc_pkg::FRAC_W-1:0]      fin_fmax;
  logic [nmea_rmc_pkg::SPD_ACC_W+nmea_rmc_pkg::KNOT_W-1:0] speed_prod;
  logic out_free;
  logic sc_free;

  assign out_free   = !out_valid_r || out_tready;
  assign sc_free    = !sc_valid_r || out_free;
  assign snap_ready = sc_free;

  // Pick the field left open when the sentence closed
  always_comb begin
    fin_acc  = '0;
    fin_max  = '0;
    fin_fmax = '0;
    unique case (snap_data.field)
      nmea_rmc_pkg::FLD_LAT: begin
        fin_acc  = nmea_rmc_pkg::ACC_W'(snap_data.lat);
        fin_max  = nmea_rmc_pkg::LAT_MAX;
        fin_fmax = nmea_rmc_pkg::FRAC_POS;
      end
      nmea_rmc_pkg::FLD_LON: begin
        fin_acc  = nmea_rmc_pkg::ACC_W'(snap_data.lon);
        fin_max  = nmea_rmc_pkg::LON_MAX;
        fin_fmax = nmea_rmc_pkg::FRAC_POS;
      end
      nmea_rmc_pkg::FLD_SPEED: begin
        fin_acc  = nmea_rmc_pkg::ACC_W'(snap_data.speed);
        fin_max  = nmea_rmc_pkg::SPD_ACC_MAX;
        fin_fmax = nmea_rmc_pkg::FRAC_SPD;
      end
      default: begin
        fin_acc = '0;
      end
    endcase
    fin_scaled   = nmea_rmc_pkg::scale_sat(fin_acc, snap_data.frac, fin_fmax, fin_max);
    sc_lat_nxt   = snap_data.lat;
    sc_lon_nxt   = snap_data.lon;
    sc_speed_nxt = snap_data.speed;
    unique case (snap_data.field)
      nmea_rmc_pkg::FLD_LAT:   sc_lat_nxt   = fin_scaled[nmea_rmc_pkg::LAT_W-1:0];
      nmea_rmc_pkg::FLD_LON:   sc_lon_nxt   = fin_scaled[nmea_rmc_pkg::LON_W-1:0];
      nmea_rmc_pkg::FLD_SPEED: sc_speed_nxt = fin_scaled[nmea_rmc_pkg::SPD_ACC_W-1:0];
      default:                 sc_lat_nxt   = snap_data.lat;
    endcase
  end

  // Register the scaled sentence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r <= 1'b0;
    end else if (sc_free) begin
      sc_valid_r <= snap_valid;
    end
    if (sc_free && snap_valid) begin
      sc_status_r <= snap_data.status;
      sc_lat_r    <= sc_lat_nxt;
      sc_lon_r    <= sc_lon_nxt;
      sc_speed_r  <= sc_speed_nxt;
      sc_head_r   <= snap_data.heading;
    end
  end

  // Knots times 100 to metres per second times 100000
  assign speed_prod = {{nmea_rmc_pkg::KNOT_W{1'b0}}, sc_speed_r} *
                      {{nmea_rmc_pkg::SPD_ACC_W{1'b0}}, nmea_rmc_pkg::KNOT_FACTOR};

  // Hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= sc_valid_r;
    end
    if (out_free && sc_valid_r) begin
      out_status_r <= sc_status_r;
      out_lat_r    <= sc_lat_r;
      out_lon_r    <= sc_lon_r;
      out_speed_r  <= speed_prod[nmea_rmc_pkg::SPD_W-1:0];
      out_head_r   <= sc_head_r;
    end
  end

  // Pack the result word, padded with zeros
  always_comb begin
    out_tdata = '0;
    out_tdata[nmea_rmc_pkg::OUT_BITS-1:0] =
      {out_head_r, out_speed_r, out_lon_r, out_lat_r, out_status_r};
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> sv/nmea_rmc_field_extractor.sv
// Top level of the RMC sentence field extractor.
// Depends on nmea_rmc_pkg, nmea_rmc_parse and nmea_rmc_finish.
//
// Usage:
//   The input channel carries one received character per word (in_tdata).
//   The block hunts for the "$GPRMC," header, then reads the sentence body
//   up to '*' or MAX_BODY body characters and sends one result word per
//   sentence on the output channel. Bytes outside a sentence produce nothing.
//   Throughput: one character per cycle, sustained, as long as results drain.
//   The closing character passes the input word register, the snapshot
//   register, the scaling stage and the output register (knots product).
//   Reset clears every valid flag and puts the parser back to header hunting.
//   When the receiver stalls, the result word holds; up to two further
//   sentence results queue in the internal stages, and only then is the
//   input held off, when a character that closes yet another sentence waits.
//   Characters that close no sentence keep flowing during a stall.
module nmea_rmc_field_extractor (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [7:0] rx_byte
  input  logic [7:0]                           in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] fix_valid, [27:1] latitude_e4, [57:28] longitude_e4,
  // [86:58] speed_mps_e5, [96:87] heading_deg, [103:97] zero
  output logic [nmea_rmc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                    snap_valid;
  logic                    snap_ready;
  nmea_rmc_pkg::sentence_t snap_data;

  // Character parser
  nmea_rmc_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_data  (snap_data)
  );

  // Final scaling and result register
  nmea_rmc_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_data  (snap_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> sv/nmea_rmc_checker.sv
// Port-level checker for the RMC field extractor, bound to the top level.
// Depends on nmea_rmc_field_extractor_assert.svh and nmea_rmc_pkg.
`include "nmea_rmc_field_extractor_assert.svh"

module nmea_rmc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic [7:0]                           in_tdata,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [nmea_rmc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // Reset empties the result register
  `NRMC_ASSERT_CLK(a_reset_clears_out, !rst_n |=> !out_tvalid)

  // With no result waiting, nothing may hold off the input
  `NRMC_ASSERT_RST(a_ready_when_drained, !out_tvalid |-> in_tready)

  // Latitude, longitude and heading stay within their saturation limits, padding zero
  `NRMC_ASSERT_RST(a_result_ranges, out_tvalid |-> (out_tdata[27:1] <= 27'd99999999) && (out_tdata[57:28] <= 30'd999999999) && (out_tdata[96:87] <= 10'd999) && (out_tdata[103:97] == 7'd0))

  // A stalled result word holds
  `NRMC_ASSERT_RST(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))

endmodule

bind nmea_rmc_field_extractor nmea_rmc_checker u_nmea_rmc_checker (.*);
